### hdl/cwf_pkg.sv
// cwf_pkg: widths, constants, register indexes and beat types for the
// cheapest window finder
// no dependencies
package cwf_pkg;

    // store depth and the widths that follow from it
    localparam int MAX_DAY_SLOTS = 64;
    localparam int IDX_W         = $clog2(MAX_DAY_SLOTS);
    localparam int CNT_W         = $clog2(MAX_DAY_SLOTS + 1);

    // field widths
    localparam int START_W = 32;
    localparam int PRICE_W = 16;
    localparam int WL_W    = 7;
    localparam int LEN_W   = (CNT_W > WL_W) ? CNT_W : WL_W;
    localparam int SUM_W   = PRICE_W + IDX_W + 1;

    // shared adder width: a 32 bit unsigned difference or a sum difference
    localparam int ALU_W     = (SUM_W + 1 > START_W + 1) ? SUM_W + 1 : START_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DAY_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd1;

    localparam logic [START_W-1:0] DAY_SECONDS = 32'd86400;

    // shared unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [START_W-1:0]        slot_start;
        logic signed [PRICE_W-1:0] slot_price;
        logic                      final_slot;
    } in_item_t;

    typedef struct packed {
        logic                      window_found;
        logic [START_W-1:0]        window_start;
        logic signed [PRICE_W-1:0] window_average;
    } out_item_t;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

endpackage

### hdl/cheapest_window_finder_core.sv
// cheapest_window_finder_core: minimum sum sliding window over one day of prices
// depends on cwf_pkg, cwf_ram and cwf_alu
//
// channel   direction  beat         handshake
// in        sink       in_item_t    in_valid / in_ready
// out       source     out_item_t   out_valid / out_ready
// cfg       sink       index, data  cfg_valid / cfg_ready
//
// a slot steps through range check, sum and compare on the single shared 33 bit
// adder; a slot outside the day skips the sum and compare steps
// a final slot with a window adds abs, one quotient bit a cycle over the sum
// width, and sign fix, again on the shared adder
// in_ready is high only while the sequencer idles; the result sits in an output
// register so the next slot is taken while the beat waits
// reset clears control and running state; the rings have no reset and need no
// clearing pass, as only entries written in the current day are read
module cheapest_window_finder_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  cwf_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output cwf_pkg::out_item_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cwf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int MAX_SLOTS = cwf_pkg::MAX_DAY_SLOTS;
    localparam int IDX_W     = cwf_pkg::IDX_W;
    localparam int CNT_W     = cwf_pkg::CNT_W;
    localparam int LEN_W     = cwf_pkg::LEN_W;
    localparam int START_W   = cwf_pkg::START_W;
    localparam int PRICE_W   = cwf_pkg::PRICE_W;
    localparam int WL_W      = cwf_pkg::WL_W;
    localparam int SUM_W     = cwf_pkg::SUM_W;
    localparam int ALU_W     = cwf_pkg::ALU_W;
    localparam int DIV_CNT_W = cwf_pkg::DIV_CNT_W;

    localparam logic [CNT_W-1:0]     KEPT_MAX = CNT_W'(MAX_SLOTS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DAY0 = 4'd1;   // start below day start?
    localparam logic [3:0] S_DAY1 = 4'd2;   // start past day end? write rings
    localparam logic [3:0] S_ADD  = 4'd3;   // add new price
    localparam logic [3:0] S_SUB  = 4'd4;   // drop price leaving the window
    localparam logic [3:0] S_CMP  = 4'd5;   // compare with best
    localparam logic [3:0] S_FIN  = 4'd6;   // end of slot, maybe emit
    localparam logic [3:0] S_ABS  = 4'd7;   // magnitude of best sum
    localparam logic [3:0] S_DIV  = 4'd8;   // one quotient bit a cycle
    localparam logic [3:0] S_NEG  = 4'd9;   // restore sign, load result

    function automatic logic [ALU_W-1:0] zext_start(input logic [START_W-1:0] v);
        return ALU_W'(v);
    endfunction

    function automatic logic [ALU_W-1:0] sext_sum(input logic [SUM_W-1:0] v);
        return {{(ALU_W - SUM_W){v[SUM_W-1]}}, v};
    endfunction

    function automatic logic [SUM_W-1:0] sext_price(input logic [PRICE_W-1:0] v);
        return {{(SUM_W - PRICE_W){v[PRICE_W-1]}}, v};
    endfunction

    // control state
    logic [3:0]           state_reg, state_next;
    logic [START_W-1:0]   day_start_reg, day_start_next;
    logic [WL_W-1:0]      window_len_reg, window_len_next;
    logic [SUM_W-1:0]     running_sum_reg, running_sum_next;
    logic [CNT_W-1:0]     kept_count_reg, kept_count_next;
    logic [SUM_W-1:0]     best_sum_reg, best_sum_next;
    logic [START_W-1:0]   best_start_reg, best_start_next;
    logic                 have_best_reg, have_best_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // payload state
    cwf_pkg::in_item_t    item_reg;
    logic [START_W-1:0]   diff_reg, diff_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [WL_W-1:0]      rem_reg, rem_next;
    cwf_pkg::out_item_t   out_data_reg, out_data_next;

    // shared unit and ring ports
    cwf_pkg::alu_req_t    alu_req;
    logic [ALU_W-1:0]     alu_res;
    logic                 alu_neg;

    logic                 ring_wr_en;
    logic                 price_rd_en;
    logic                 start_rd_en;
    logic [PRICE_W-1:0]   price_rd;
    logic [START_W-1:0]   start_rd;

    logic                 in_accept;
    logic                 do_clear;
    logic [LEN_W-1:0]     kept_len;
    logic [LEN_W-1:0]     wl_len;
    logic [LEN_W-1:0]     back_len;
    logic [LEN_W-1:0]     first_len;
    logic                 wl_nonzero;
    logic                 window_full;
    logic [WL_W:0]        div_shift;
    logic                 quo_bit;
    logic [PRICE_W-1:0]   avg_val;

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ring addresses: entry leaving the window and first entry of the window
    assign kept_len    = LEN_W'(kept_count_reg);
    assign wl_len      = LEN_W'(window_len_reg);
    assign back_len    = kept_len - wl_len;
    assign first_len   = kept_len + LEN_W'(1) - wl_len;
    assign wl_nonzero  = (window_len_reg != '0);
    assign window_full = wl_nonzero && (kept_len >= wl_len);

    assign alu_neg   = alu_res[ALU_W-1];
    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};

    cwf_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    cwf_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_SLOTS)
    ) u_price_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (kept_count_reg[IDX_W-1:0]),
        .wr_data (item_reg.slot_price),
        .rd_en   (price_rd_en),
        .rd_addr (back_len[IDX_W-1:0]),
        .rd_data (price_rd)
    );

    cwf_ram #(
        .WIDTH (START_W),
        .DEPTH (MAX_SLOTS)
    ) u_start_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (kept_count_reg[IDX_W-1:0]),
        .wr_data (item_reg.slot_start),
        .rd_en   (start_rd_en),
        .rd_addr (first_len[IDX_W-1:0]),
        .rd_data (start_rd)
    );

    always_comb
    begin
        state_next       = state_reg;
        day_start_next   = day_start_reg;
        window_len_next  = window_len_reg;
        running_sum_next = running_sum_reg;
        kept_count_next  = kept_count_reg;
        best_sum_next    = best_sum_reg;
        best_start_next  = best_start_reg;
        have_best_next   = have_best_reg;
        div_cnt_next     = div_cnt_reg;
        diff_next        = diff_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg;
        alu_req.op       = cwf_pkg::ALU_ADD;
        alu_req.a        = '0;
        alu_req.b        = '0;
        ring_wr_en       = 1'b0;
        price_rd_en      = 1'b0;
        start_rd_en      = 1'b0;
        do_clear         = 1'b0;
        quo_bit          = 1'b0;
        avg_val          = '0;

        // waiting beat leaves
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (cfg_index)
                        cwf_pkg::REG_DAY_START:
                        begin
                            day_start_next = cfg_data[START_W-1:0];
                            do_clear       = 1'b1;
                        end
                        cwf_pkg::REG_WINDOW_LEN:
                        begin
                            window_len_next = cfg_data[WL_W-1:0];
                            do_clear        = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (in_valid)
                begin
                    state_next = S_DAY0;
                end
            end

            S_DAY0:
            begin
                alu_req.op = cwf_pkg::ALU_SUB;
                alu_req.a  = zext_start(item_reg.slot_start);
                alu_req.b  = zext_start(day_start_reg);
                diff_next  = alu_res[START_W-1:0];
                state_next = alu_neg ? S_FIN : S_DAY1;
            end

            S_DAY1:
            begin
                alu_req.op = cwf_pkg::ALU_SUB;
                alu_req.a  = zext_start(diff_reg);
                alu_req.b  = zext_start(cwf_pkg::DAY_SECONDS);
                if (alu_neg && (kept_count_reg < KEPT_MAX))
                begin
                    ring_wr_en  = 1'b1;
                    price_rd_en = 1'b1;
                    state_next  = S_ADD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_ADD:
            begin
                alu_req.op       = cwf_pkg::ALU_ADD;
                alu_req.a        = sext_sum(running_sum_reg);
                alu_req.b        = sext_sum(sext_price(item_reg.slot_price));
                running_sum_next = alu_res[SUM_W-1:0];
                // read after the ring write so a one slot window sees this slot
                start_rd_en      = 1'b1;
                state_next       = S_SUB;
            end

            S_SUB:
            begin
                kept_count_next = kept_count_reg + CNT_W'(1);
                if (window_full)
                begin
                    alu_req.op       = cwf_pkg::ALU_SUB;
                    alu_req.a        = sext_sum(running_sum_reg);
                    alu_req.b        = sext_sum(sext_price(price_rd));
                    running_sum_next = alu_res[SUM_W-1:0];
                end
                state_next = S_CMP;
            end

            S_CMP:
            begin
                alu_req.op = cwf_pkg::ALU_SUB;
                alu_req.a  = sext_sum(running_sum_reg);
                alu_req.b  = sext_sum(best_sum_reg);
                // strictly smaller only, so the earliest window stays
                if (window_full && (!have_best_reg || alu_neg))
                begin
                    have_best_next  = 1'b1;
                    best_sum_next   = running_sum_reg;
                    best_start_next = start_rd;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!item_reg.final_slot)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    if (have_best_reg && wl_nonzero)
                    begin
                        state_next = S_ABS;
                    end
                    else
                    begin
                        out_data_next.window_found   = 1'b0;
                        out_data_next.window_start   = '0;
                        out_data_next.window_average = '0;
                        out_valid_next               = 1'b1;
                        do_clear                     = 1'b1;
                        state_next                   = S_IDLE;
                    end
                end
            end

            S_ABS:
            begin
                alu_req.op   = cwf_pkg::ALU_SUB;
                alu_req.a    = '0;
                alu_req.b    = sext_sum(best_sum_reg);
                quo_next     = best_sum_reg[SUM_W-1] ? alu_res[SUM_W-1:0] : best_sum_reg;
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            S_DIV:
            begin
                // restoring step, quotient bits shift in behind the dividend
                alu_req.op = cwf_pkg::ALU_SUB;
                alu_req.a  = ALU_W'(div_shift);
                alu_req.b  = ALU_W'(window_len_reg);
                if (!alu_neg)
                begin
                    rem_next = alu_res[WL_W-1:0];
                    quo_bit  = 1'b1;
                end
                else
                begin
                    rem_next = div_shift[WL_W-1:0];
                    quo_bit  = 1'b0;
                end
                quo_next = {quo_reg[SUM_W-2:0], quo_bit};
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_NEG;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                end
            end

            S_NEG:
            begin
                alu_req.op = cwf_pkg::ALU_SUB;
                alu_req.a  = '0;
                alu_req.b  = ALU_W'(quo_reg);
                avg_val    = best_sum_reg[SUM_W-1] ? alu_res[PRICE_W-1:0]
                                                   : quo_reg[PRICE_W-1:0];
                out_data_next.window_found   = 1'b1;
                out_data_next.window_start   = best_start_reg;
                out_data_next.window_average = avg_val;
                out_valid_next               = 1'b1;
                do_clear                     = 1'b1;
                state_next                   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // day accumulation starts over; rings keep their contents
        if (do_clear)
        begin
            running_sum_next = '0;
            kept_count_next  = '0;
            best_sum_next    = '0;
            best_start_next  = '0;
            have_best_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            day_start_reg   <= '0;
            window_len_reg  <= WL_W'(1);
            running_sum_reg <= '0;
            kept_count_reg  <= '0;
            best_sum_reg    <= '0;
            best_start_reg  <= '0;
            have_best_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            day_start_reg   <= day_start_next;
            window_len_reg  <= window_len_next;
            running_sum_reg <= running_sum_next;
            kept_count_reg  <= kept_count_next;
            best_sum_reg    <= best_sum_next;
            best_start_reg  <= best_start_next;
            have_best_reg   <= have_best_next;
            out_valid_reg   <= out_valid_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_data;
        end
        diff_reg     <= diff_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    // a slot beat always holds off the next one, with in_ready low in the following cycle
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high straight after a slot beat");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= KEPT_MAX)
        else $error("kept count beyond store depth");

    a_best_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
        have_best_reg |-> window_len_reg != '0)
        else $error("best window held with zero window length");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.window_found |->
            out_data.window_start == '0 && out_data.window_average == '0)
        else $error("no window result carries non-zero fields");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |=> state_reg == S_DIV || state_reg == S_NEG)
        else $error("divider left other than through sign fix");

endmodule

### hdl/cwf_ram.sv
// cwf_ram: generic single write port, single read port ram with registered read
// no dependencies
module cwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/cwf_alu.sv
// cwf_alu: the shared add / subtract unit used by the arithmetic steps of the sequencer
// depends on cwf_pkg
module cwf_alu (
    input  cwf_pkg::alu_req_t          req,
    output logic [cwf_pkg::ALU_W-1:0]  res
);

    always_comb
    begin
        case (req.op)
            cwf_pkg::ALU_SUB: res = req.a - req.b;
            default:          res = req.a + req.b;
        endcase
    end

endmodule
